### rtl/hsb_to_rgb_converter_macros.svh
// ----------------------------------------------------------------------------
// HSB to RGB converter assertion macros
// Shared concurrent assertion forms for the converter RTL.
// ----------------------------------------------------------------------------
`ifndef HSB_TO_RGB_CONVERTER_MACROS_SVH
`define HSB_TO_RGB_CONVERTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checks a property on every rising clock edge outside reset.
`define HSB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a trigger is followed by a consequence a fixed number of cycles later.
`define HSB_ASSERT_DELAY(lbl, clk, rst, trig, dly, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> ##dly (cons)) \
      else $error(msg);
`else
`define HSB_ASSERT(lbl, clk, rst, prop, msg)
`define HSB_ASSERT_DELAY(lbl, clk, rst, trig, dly, cons, msg)
`endif

`endif

### rtl/hsbrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSB to RGB converter package
// Payload types, wheel segment codes and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package hsbrgb_pkg;

   localparam logic [7:0] FULL_LEVEL = 8'd255;

   // Hue bits [9:8] select a wheel segment; code 3 is hue 768..1023,
   // which wraps onto the red-to-green segment.
   localparam logic [1:0] SEG_RED_GREEN  = 2'd0;
   localparam logic [1:0] SEG_GREEN_BLUE = 2'd1;
   localparam logic [1:0] SEG_BLUE_RED   = 2'd2;
   localparam logic [1:0] SEG_WRAP       = 2'd3;

   typedef struct packed {
      logic [9:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } hsb_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } hsb_rsp_type;

   // Output of the wheel stage: raw channel ramps plus the two scale factors.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } wheel_type;

   // Exact floor(x / 255) for x up to 255 * 255.
   function automatic logic [7:0] div_by_full(input logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

### rtl/hsb_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSB to RGB converter
// Converts hue, saturation and brightness into an 8-bit RGB triple.
// ----------------------------------------------------------------------------
// Usage: raise start with a color on req_data; the transfer takes place at
// each rising edge where start is high and busy is low. Busy is always low,
// so a new color may be offered on every clock cycle.
// Each result appears on rsp_data marked by rsp_valid for exactly one
// cycle. Results leave in request order.
// The pipeline is the hue wheel decode stage followed by the stages of each
// channel shader (saturation multiply, divide and offset, brightness
// multiply, final divide). Throughput is one color per cycle, set by the
// fully pipelined shaders.
// Hue values from 768 to 1023 wrap onto the wheel by subtracting 768.
// Reset clears every stage valid bit; items in flight are dropped and no
// result strobes until new requests arrive.
// The receiver cannot stall: each result is present for one cycle only, so
// the pipeline never holds and busy stays low.
// ----------------------------------------------------------------------------
`include "hsb_to_rgb_converter_macros.svh"

module hsb_to_rgb_converter import hsbrgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  hsb_req_type req_data,
   output logic        rsp_valid,
   output hsb_rsp_type rsp_data
);

   logic       wheel_valid;
   wheel_type  wheel_data;
   logic       red_valid;
   logic       green_valid;
   logic       blue_valid;
   logic       accept;
   logic [7:0] red_shade;
   logic [7:0] green_shade;
   logic [7:0] blue_shade;
   // Conditions watched by the assertions below.
   logic       lanes_agree;
   logic       black_req;
   logic       white_req;
   logic       white_rsp;

   // The pipeline advances every cycle, so there is never a reason to refuse
   // a request transfer.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Stage 0: segment decode into three raw channel ramps.
   hsbrgb_wheel u_wheel (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .out_valid (wheel_valid),
      .out_data  (wheel_data)
   );

   // Three identical shaders run in lockstep, one per channel.
   hsbrgb_shade u_shade_red (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (wheel_valid),
      .level      (wheel_data.red),
      .saturation (wheel_data.saturation),
      .brightness (wheel_data.brightness),
      .out_valid  (red_valid),
      .shade      (red_shade)
   );

   hsbrgb_shade u_shade_green (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (wheel_valid),
      .level      (wheel_data.green),
      .saturation (wheel_data.saturation),
      .brightness (wheel_data.brightness),
      .out_valid  (green_valid),
      .shade      (green_shade)
   );

   hsbrgb_shade u_shade_blue (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (wheel_valid),
      .level      (wheel_data.blue),
      .saturation (wheel_data.saturation),
      .brightness (wheel_data.brightness),
      .out_valid  (blue_valid),
      .shade      (blue_shade)
   );

   // The three lanes are packed into the result in one place.
   assign rsp_data.red   = red_shade;
   assign rsp_data.green = green_shade;
   assign rsp_data.blue  = blue_shade;

   // The red lane's valid marks the result; the other lanes must agree.
   assign rsp_valid = red_valid;

   assign lanes_agree = (red_valid == green_valid) && (red_valid == blue_valid);
   assign black_req   = accept && (req_data.brightness == 8'd0);
   assign white_req   = accept && (req_data.saturation == 8'd0) &&
                        (req_data.brightness == FULL_LEVEL);
   assign white_rsp   = (red_shade == FULL_LEVEL) && (green_shade == FULL_LEVEL) &&
                        (blue_shade == FULL_LEVEL);

   `HSB_ASSERT(a_lanes_agree, clock, reset, lanes_agree, "channel lanes out of step")
   `HSB_ASSERT_DELAY(a_latency, clock, reset, accept, 5, rsp_valid, "result missing")
   `HSB_ASSERT_DELAY(a_black, clock, reset, black_req, 5, rsp_data == '0, "not black")
   `HSB_ASSERT_DELAY(a_white, clock, reset, white_req, 5, white_rsp, "not white")

endmodule

### rtl/hsbrgb_wheel.sv
// ----------------------------------------------------------------------------
// HSB to RGB wheel stage
// Decodes the hue segment and registers the three raw channel ramps.
// ----------------------------------------------------------------------------
module hsbrgb_wheel import hsbrgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  hsb_req_type in_data,
   output logic        out_valid,
   output wheel_type   out_data
);

   logic      valid_ff;
   wheel_type data_ff;
   wheel_type data_in;
   logic [7:0] pos;

   assign pos = in_data.hue[7:0];

   always_comb begin
      data_in            = '0;
      data_in.saturation = in_data.saturation;
      data_in.brightness = in_data.brightness;
      unique case (in_data.hue[9:8])
         SEG_RED_GREEN, SEG_WRAP: begin
            data_in.red   = FULL_LEVEL - pos;
            data_in.green = pos;
         end
         SEG_GREEN_BLUE: begin
            data_in.green = FULL_LEVEL - pos;
            data_in.blue  = pos;
         end
         SEG_BLUE_RED: begin
            data_in.blue = FULL_LEVEL - pos;
            data_in.red  = pos;
         end
         default: begin
            data_in.red = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/hsbrgb_shade.sv
// ----------------------------------------------------------------------------
// HSB to RGB channel shader
// Four-stage pipeline scaling one channel by saturation and brightness.
// ----------------------------------------------------------------------------
module hsbrgb_shade import hsbrgb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] level,
   input  logic [7:0] saturation,
   input  logic [7:0] brightness,
   output logic       out_valid,
   output logic [7:0] shade
);

   // Valid bit for each of the four stages.
   logic [3:0]  valid_ff;
   logic [3:0]  valid_in;

   // Stage 1: level times saturation.
   logic [15:0] sat_prod_ff;
   logic [15:0] sat_prod_in;
   logic [7:0]  sat_ff;
   logic [7:0]  bri1_ff;
   // Stage 2: saturated level plus white offset.
   logic [7:0]  mixed_ff;
   logic [7:0]  mixed_in;
   logic [7:0]  bri2_ff;
   // Stage 3: times brightness.
   logic [15:0] bri_prod_ff;
   logic [15:0] bri_prod_in;
   // Stage 4: final scale.
   logic [7:0]  shade_ff;
   logic [7:0]  shade_in;

   assign valid_in    = {valid_ff[2:0], in_valid};
   assign sat_prod_in = level * saturation;
   // The sum stays at or below 255 since level never exceeds 255.
   assign mixed_in    = div_by_full(sat_prod_ff) + (FULL_LEVEL - sat_ff);
   assign bri_prod_in = mixed_ff * bri2_ff;
   assign shade_in    = div_by_full(bri_prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sat_prod_ff <= sat_prod_in;
      sat_ff      <= saturation;
      bri1_ff     <= brightness;
      mixed_ff    <= mixed_in;
      bri2_ff     <= bri1_ff;
      bri_prod_ff <= bri_prod_in;
      shade_ff    <= shade_in;
   end

   assign out_valid = valid_ff[3];
   assign shade     = shade_ff;

endmodule

### sim/tb_hsb_to_rgb_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSB to RGB converter testbench
// Feeds directed and random colors through the converter and checks every
// RGB result against an in-bench prediction of the three-segment hue wheel.
// ----------------------------------------------------------------------------
module tb_hsb_to_rgb_converter;
   import hsbrgb_pkg::*;

   // The run ends with a failure if it takes longer than this.
   localparam int CYCLE_LIMIT  = 100000;
   // Cycles to wait after the last result, a few times the pipeline depth.
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_COLORS = 1900;
   // Idling is switched off for transfers in this window.
   localparam int STEADY_FIRST = 800;
   localparam int STEADY_LAST  = 1200;

   // A color waiting to be offered. When drain_first is set, the color is
   // held back until every result in flight has come out.
   typedef struct {
      hsb_req_type color;
      bit          drain_first;
   } queued_color_type;

   // An expected result, kept with the color that caused it for reporting.
   typedef struct {
      hsb_req_type color;
      hsb_rsp_type rgb;
   } expected_rgb_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   hsb_req_type req_data = '0;
   logic        rsp_valid;
   hsb_rsp_type rsp_data;

   queued_color_type pending_colors[$];
   expected_rgb_type expected_rgb[$];
   int unsigned      accepted_count = 0;
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;

   hsb_to_rgb_converter DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Scales one raw channel ramp by saturation, adds the white offset, then
   // scales by brightness. Both divisions truncate; the result is clamped.
   function automatic logic [7:0] shade_channel(input int unsigned level,
                                                input int unsigned sat,
                                                input int unsigned bri);
      int unsigned tone;
      tone = (level * sat) / 255 + (255 - sat);
      tone = (tone * bri) / 255;
      if (tone > 255) begin
         tone = 255;
      end
      return tone[7:0];
   endfunction

   // Predicts the RGB triple for one color. The hue wraps modulo 768, and
   // the wrapped hue picks one of three 256-wide segments. Within a segment
   // one channel ramps down, the next ramps up and the third stays at zero.
   function automatic hsb_rsp_type predict_rgb(input hsb_req_type color);
      logic [9:0]  wheel_pos;
      logic [7:0]  seg_pos;
      int unsigned ramp_red, ramp_green, ramp_blue;
      hsb_rsp_type rgb;
      wheel_pos = (color.hue >= 10'd768) ? color.hue - 10'd768 : color.hue;
      seg_pos = wheel_pos[7:0];
      if (wheel_pos < 10'd256) begin
         ramp_red   = 255 - seg_pos;
         ramp_green = seg_pos;
         ramp_blue  = 0;
      end else if (wheel_pos < 10'd512) begin
         ramp_red   = 0;
         ramp_green = 255 - seg_pos;
         ramp_blue  = seg_pos;
      end else begin
         ramp_red   = seg_pos;
         ramp_green = 0;
         ramp_blue  = 255 - seg_pos;
      end
      rgb.red   = shade_channel(ramp_red, color.saturation, color.brightness);
      rgb.green = shade_channel(ramp_green, color.saturation, color.brightness);
      rgb.blue  = shade_channel(ramp_blue, color.saturation, color.brightness);
      return rgb;
   endfunction

   task automatic queue_color(input int unsigned hue, input int unsigned sat,
                              input int unsigned bri, input bit drain_first = 1'b0);
      queued_color_type entry;
      entry.color.hue        = hue[9:0];
      entry.color.saturation = sat[7:0];
      entry.color.brightness = bri[7:0];
      entry.drain_first      = drain_first;
      pending_colors.push_back(entry);
   endtask

   // Saturation and brightness are drawn mostly at random, with the two
   // extremes made more likely so that white and black come up often.
   function automatic int unsigned random_level();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         return 0;
      end else if (pick < 20) begin
         return 255;
      end
      return $urandom_range(255);
   endfunction

   // Stimulus: the directed colors first, then the random part. All of it is
   // queued before reset is released; the driver takes it from there.
   initial begin
      // Segment boundaries at full saturation and brightness.
      queue_color(0, 255, 255);
      queue_color(255, 255, 255);
      queue_color(256, 255, 255);
      queue_color(511, 255, 255);
      queue_color(512, 255, 255);
      queue_color(767, 255, 255);
      // Hues above 767 wrap back onto the first segment.
      queue_color(768, 255, 255);
      queue_color(1023, 255, 255);
      queue_color(900, 200, 180);
      // Zero saturation gives white before the brightness scale.
      queue_color(100, 0, 255);
      queue_color(600, 0, 128);
      // Zero brightness turns every channel off.
      queue_color(300, 255, 0);
      queue_color(1023, 0, 0);
      // Smallest nonzero scale factors and some midrange points.
      queue_color(128, 1, 255);
      queue_color(383, 255, 1);
      queue_color(640, 1, 1);
      queue_color(128, 128, 200);
      queue_color(450, 77, 254);
      queue_color(700, 254, 99);
      queue_color(1000, 170, 85);
      // Let the pipeline empty completely before the random part starts.
      queue_color($urandom_range(1023), random_level(), random_level(), 1'b1);
      for (int i = 1; i < RANDOM_COLORS; i++) begin
         // A second full drain partway through the random part.
         queue_color($urandom_range(1023), random_level(), random_level(),
                     i == RANDOM_COLORS / 2);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last color to transfer and its result to come out.
      @(posedge clock);
      while (pending_colors.size() != 0 || start || expected_rgb.size() != 0) begin
         @(posedge clock);
      end
      // Anything that shows up now has no expectation and counts as an error.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Driver. A transfer takes place at a rising edge with start high and
   // busy low; the prediction is made at that edge. An offer that is not
   // taken stays on the bus unchanged. Otherwise the next color is offered
   // unless the driver idles at random or must first let the pipeline drain.
   always @(posedge clock) begin : drive_colors
      logic hold_offer;
      logic idle_allowed;
      if (reset) begin
         start <= 1'b0;
      end else begin
         hold_offer = start && busy;
         if (start && !busy) begin
            expected_rgb.push_back('{color: req_data, rgb: predict_rgb(req_data)});
            accepted_count++;
         end
         idle_allowed = accepted_count < STEADY_FIRST || accepted_count >= STEADY_LAST;
         if (!hold_offer) begin
            if (pending_colors.size() == 0) begin
               start <= 1'b0;
            end else if (pending_colors[0].drain_first && expected_rgb.size() != 0) begin
               start <= 1'b0;
            end else if (idle_allowed && $urandom_range(99) < 13) begin
               start <= 1'b0;
            end else begin
               start    <= 1'b1;
               req_data <= pending_colors.pop_front().color;
            end
         end
      end
   end

   task automatic check_channel(input string channel, input logic [7:0] expected_level,
                                input logic [7:0] actual_level, input hsb_req_type color);
      if (actual_level !== expected_level) begin
         error_count++;
         $display("%0t: %s mismatch for hue %0d sat %0d bri %0d: expected %0d, actual %0d",
                  $time, channel, color.hue, color.saturation, color.brightness,
                  expected_level, actual_level);
      end
   endtask

   // Monitor. The receiver cannot hold results off, so each strobe is one
   // result, taken at the edge that ends its cycle and compared field by
   // field with the oldest expectation.
   always @(posedge clock) begin : check_results
      expected_rgb_type oldest;
      if (!reset && rsp_valid) begin
         if (expected_rgb.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: expected none, actual r %0d g %0d b %0d",
                     $time, rsp_data.red, rsp_data.green, rsp_data.blue);
         end else begin
            oldest = expected_rgb.pop_front();
            check_channel("red", oldest.rgb.red, rsp_data.red, oldest.color);
            check_channel("green", oldest.rgb.green, rsp_data.green, oldest.color);
            check_channel("blue", oldest.rgb.blue, rsp_data.blue, oldest.color);
         end
      end
   end

   // Guard against a hang: a stuck busy or a lost result ends the run here.
   always @(posedge clock) begin : watch_cycles
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule

### filelist.f
+incdir+rtl
rtl/hsbrgb_pkg.sv
rtl/hsbrgb_wheel.sv
rtl/hsbrgb_shade.sv
rtl/hsb_to_rgb_converter.sv
sim/tb_hsb_to_rgb_converter.sv
